// File: sv/matrix_add_sub_scale_multiply_macros.svh
// ----------------------------------------------------------------------------
// matrix_add_sub_scale_multiply_macros
// assertion macros used by the matrix engine top module
// ----------------------------------------------------------------------------
`ifndef MATRIX_ADD_SUB_SCALE_MULTIPLY_MACROS_SVH
`define MATRIX_ADD_SUB_SCALE_MULTIPLY_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MXOPS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mxops assertion failed");
// next-cycle implication
`define MXOPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mxops assertion failed");
`else
`define MXOPS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define MXOPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/mxops_pkg.sv
// ----------------------------------------------------------------------------
// mxops_pkg
// types and constants of the integer matrix engine
// ----------------------------------------------------------------------------
package mxops_pkg;

    localparam int ELEM_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int PROD_W     = ELEM_W + SCALE_W;
    localparam int VALUE_W    = 40;
    localparam int IDX_OUT_W  = 3;
    localparam int CFG_DIM_W  = 4;
    localparam int MODE_W     = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_SUB   = 2'd1,
        MODE_MUL   = 2'd2,
        MODE_SCALE = 2'd3
    } t_mode;

    typedef enum logic {
        ST_LOAD,
        ST_RUN
    } t_state;

    localparam logic [REG_IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INNER_COUNT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COL_COUNT    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd4;

    localparam t_mode                   RST_MODE  = MODE_MUL;
    localparam logic [CFG_DIM_W-1:0]    RST_DIM   = 4'd1;
    localparam logic signed [SCALE_W-1:0] RST_SCALE = 16'sd1;

    typedef struct packed {
        logic                     operand_select;
        logic signed [ELEM_W-1:0] element;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [IDX_OUT_W-1:0]      out_row;
        logic [IDX_OUT_W-1:0]      out_col;
        logic                      last;
    } t_out_item;

    // control that travels alongside each read of the stores
    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last_k;
        logic [IDX_OUT_W-1:0] row;
        logic [IDX_OUT_W-1:0] col;
        logic                 last;
    } t_tag;

endpackage

// File: sv/matrix_add_sub_scale_multiply.sv
// ----------------------------------------------------------------------------
// matrix_add_sub_scale_multiply
// integer matrix engine: add, subtract, scale by factor and matrix multiply
// ----------------------------------------------------------------------------
// Elements are loaded one item per cycle (start while busy is low) into two
// single-port-read stores; the item that completes the operands raises busy.
// Results then stream out row-major, one strobe per result, and cannot be
// held off. In multiply mode one multiply-accumulate unit walks the stores
// one step per cycle, summing inner_count products into each result; the
// other modes give one result per cycle. Operands pass the store read
// registers and the term register before reaching the result register, and
// busy falls as the last result is registered. There is no clearing pass
// after reset. Any write to a mapped register abandons a partial load.
`include "matrix_add_sub_scale_multiply_macros.svh"

module matrix_add_sub_scale_multiply
    import mxops_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    output t_out_item             o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] r);
        if (r == '0) begin
            return DIM_W'(1);
        end else if (int'(r) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end else begin
            return DIM_W'(r);
        end
    endfunction

    t_mode                     r_mode;
    logic [CFG_DIM_W-1:0]      r_row_count;
    logic [CFG_DIM_W-1:0]      r_inner_count;
    logic [CFG_DIM_W-1:0]      r_col_count;
    logic signed [SCALE_W-1:0] r_scale_factor;

    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;
    logic                 cfg_hit;

    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] inner;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] kdim;
    logic [DIM_W-1:0] jdim;
    logic [CNT_W-1:0] need_a;
    logic [CNT_W-1:0] need_b;
    logic             is_mul;

    logic [CNT_W-1:0] r_first_loaded;
    logic [CNT_W-1:0] r_second_loaded;
    logic [CNT_W-1:0] n_first_loaded;
    logic [CNT_W-1:0] n_second_loaded;
    logic             accept;
    logic             wr_a;
    logic             wr_b;
    logic             complete;

    t_state r_state;
    t_state n_state;
    logic   issue;
    logic   pipe_busy;

    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_k;
    logic             last_i;
    logic             last_j;
    logic             last_k;
    logic             step_last;
    logic [IDX_W-1:0] a_col;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;

    logic signed [ELEM_W-1:0] mem_a [DEPTH];
    logic signed [ELEM_W-1:0] mem_b [DEPTH];
    logic signed [ELEM_W-1:0] r_a_rd;
    logic signed [ELEM_W-1:0] r_b_rd;
    t_tag                     n_tag1;
    t_tag                     r_tag1;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            REG_MODE:         cfg_hit = 1'b1;
            REG_ROW_COUNT:    cfg_hit = 1'b1;
            REG_INNER_COUNT:  cfg_hit = 1'b1;
            REG_COL_COUNT:    cfg_hit = 1'b1;
            REG_SCALE_FACTOR: cfg_hit = 1'b1;
            default:          cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= RST_MODE;
            r_row_count    <= RST_DIM;
            r_inner_count  <= RST_DIM;
            r_col_count    <= RST_DIM;
            r_scale_factor <= RST_SCALE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MODE:         r_mode         <= t_mode'(pwdata[MODE_W-1:0]);
                REG_ROW_COUNT:    r_row_count    <= pwdata[CFG_DIM_W-1:0];
                REG_INNER_COUNT:  r_inner_count  <= pwdata[CFG_DIM_W-1:0];
                REG_COL_COUNT:    r_col_count    <= pwdata[CFG_DIM_W-1:0];
                REG_SCALE_FACTOR: r_scale_factor <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MODE:         prdata = APB_DATA_W'(r_mode);
            REG_ROW_COUNT:    prdata = APB_DATA_W'(r_row_count);
            REG_INNER_COUNT:  prdata = APB_DATA_W'(r_inner_count);
            REG_COL_COUNT:    prdata = APB_DATA_W'(r_col_count);
            REG_SCALE_FACTOR: prdata = APB_DATA_W'(unsigned'(r_scale_factor));
            default:          prdata = '0;
        endcase
    end

    // sizes
    assign rows   = clamp_dim(r_row_count);
    assign inner  = clamp_dim(r_inner_count);
    assign cols   = clamp_dim(r_col_count);
    assign is_mul = (r_mode == MODE_MUL);
    assign kdim   = is_mul ? inner : DIM_W'(1);
    assign jdim   = is_mul ? cols : inner;
    assign need_a = CNT_W'(rows) * CNT_W'(inner);

    always_comb begin
        case (r_mode)
            MODE_MUL:   need_b = CNT_W'(inner) * CNT_W'(cols);
            MODE_SCALE: need_b = '0;
            default:    need_b = need_a;
        endcase
    end

    // operand loading
    assign accept          = start && !busy;
    assign wr_a            = accept && !i_in_item.operand_select && (r_first_loaded < need_a);
    assign wr_b            = accept && i_in_item.operand_select && (r_second_loaded < need_b);
    assign n_first_loaded  = r_first_loaded + CNT_W'(wr_a);
    assign n_second_loaded = r_second_loaded + CNT_W'(wr_b);
    assign complete        = (wr_a || wr_b) && (n_first_loaded >= need_a)
                             && (n_second_loaded >= need_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_loaded  <= '0;
            r_second_loaded <= '0;
        end else if ((cfg_wr && cfg_hit) || complete) begin
            r_first_loaded  <= '0;
            r_second_loaded <= '0;
        end else begin
            r_first_loaded  <= n_first_loaded;
            r_second_loaded <= n_second_loaded;
        end
    end

    // sequencer
    assign last_i    = (DIM_W'(r_i) + DIM_W'(1)) == rows;
    assign last_j    = (DIM_W'(r_j) + DIM_W'(1)) == jdim;
    assign last_k    = (DIM_W'(r_k) + DIM_W'(1)) == kdim;
    assign step_last = last_i && last_j && last_k;

    always_comb begin
        case (r_state)
            ST_LOAD: n_state = complete ? ST_RUN : ST_LOAD;
            ST_RUN:  n_state = step_last ? ST_LOAD : ST_RUN;
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_RUN: begin
                issue = 1'b1;
                busy  = 1'b1;
            end
            default: begin
                issue = 1'b0;
                busy  = r_tag1.valid || pipe_busy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else if (complete) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else if (issue) begin
            if (!last_k) begin
                r_k <= r_k + IDX_W'(1);
            end else begin
                r_k <= '0;
                if (!last_j) begin
                    r_j <= r_j + IDX_W'(1);
                end else begin
                    r_j <= '0;
                    r_i <= last_i ? '0 : r_i + IDX_W'(1);
                end
            end
        end
    end

    assign a_col     = is_mul ? r_k : r_j;
    assign rd_addr_a = ADDR_W'(r_i) * ADDR_W'(inner) + ADDR_W'(a_col);
    assign rd_addr_b = is_mul ? ADDR_W'(r_k) * ADDR_W'(cols) + ADDR_W'(r_j) : rd_addr_a;

    // operand stores
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[r_first_loaded[ADDR_W-1:0]] <= i_in_item.element;
        end
        if (issue) begin
            r_a_rd <= mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            mem_b[r_second_loaded[ADDR_W-1:0]] <= i_in_item.element;
        end
        if (issue) begin
            r_b_rd <= mem_b[rd_addr_b];
        end
    end

    always_comb begin
        n_tag1.valid  = issue;
        n_tag1.first  = (r_k == '0);
        n_tag1.last_k = last_k;
        n_tag1.row    = IDX_OUT_W'(r_i);
        n_tag1.col    = IDX_OUT_W'(r_j);
        n_tag1.last   = last_i && last_j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
        end else begin
            r_tag1 <= n_tag1;
        end
    end

    mxops_pipe u_pipe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (r_mode),
        .i_scale_factor (r_scale_factor),
        .i_tag          (r_tag1),
        .i_a_elem       (r_a_rd),
        .i_b_elem       (r_b_rd),
        .o_out_valid    (o_out_valid),
        .o_out_item     (o_out_item),
        .o_busy         (pipe_busy)
    );

    `MXOPS_ASSERT_NEXT(a_last_ends_burst, i_clk, i_rst_n, o_out_valid && o_out_item.last, !o_out_valid)
    `MXOPS_ASSERT_IMPLIES(a_run_counts_clear, i_clk, i_rst_n, r_state == ST_RUN, r_first_loaded == '0 && r_second_loaded == '0)
    `MXOPS_ASSERT_NEXT(a_run_leaves_read, i_clk, i_rst_n, r_state == ST_RUN, r_state == ST_RUN || r_tag1.valid)
    `MXOPS_ASSERT_IMPLIES(a_no_store_write_in_run, i_clk, i_rst_n, r_state == ST_RUN, !wr_a && !wr_b)

endmodule

// File: sv/mxops_pipe.sv
// ----------------------------------------------------------------------------
// mxops_pipe
// term stage (add, subtract or multiply) and accumulate stage with result
// register
// ----------------------------------------------------------------------------
module mxops_pipe
    import mxops_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mode                     i_mode,
    input  logic signed [SCALE_W-1:0] i_scale_factor,
    input  t_tag                      i_tag,
    input  logic signed [ELEM_W-1:0]  i_a_elem,
    input  logic signed [ELEM_W-1:0]  i_b_elem,
    output logic                      o_out_valid,
    output t_out_item                 o_out_item,
    output logic                      o_busy
);

    logic signed [SCALE_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [VALUE_W-1:0] n_term;
    logic signed [VALUE_W-1:0] r_term;
    t_tag                      r_tag2;
    logic signed [VALUE_W-1:0] n_acc;
    logic signed [VALUE_W-1:0] r_acc;
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    assign mul_b = (i_mode == MODE_SCALE) ? i_scale_factor : SCALE_W'(i_b_elem);
    assign prod  = PROD_W'(i_a_elem) * PROD_W'(mul_b);

    always_comb begin
        case (i_mode)
            MODE_ADD: n_term = VALUE_W'(i_a_elem) + VALUE_W'(i_b_elem);
            MODE_SUB: n_term = VALUE_W'(i_a_elem) - VALUE_W'(i_b_elem);
            default:  n_term = VALUE_W'(prod);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2 <= '0;
        end else begin
            r_tag2 <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tag.valid) begin
            r_term <= n_term;
        end
    end

    assign n_acc = r_tag2.first ? r_term : r_acc + r_term;

    always_ff @(posedge i_clk) begin
        if (r_tag2.valid) begin
            r_acc <= n_acc;
        end
        if (r_tag2.valid && r_tag2.last_k) begin
            r_out_item.value   <= n_acc;
            r_out_item.out_row <= r_tag2.row;
            r_out_item.out_col <= r_tag2.col;
            r_out_item.last    <= r_tag2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_tag2.valid && r_tag2.last_k;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_busy      = r_tag2.valid;

endmodule

// File: verif/matrix_add_sub_scale_multiply_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_add_sub_scale_multiply_tb
// ----------------------------------------------------------------------------
// Self-checking bench for the integer matrix engine. Operand elements are
// driven through the start/busy command port and registers through the APB
// port. A local model of the engine predicts every result element, and each
// strobed result is compared in order against it. Directed checks cover
// reset defaults, operand extremes, ignored items, clamped sizes and loads
// abandoned by a register write. They are followed by random configurations
// and loads with idle bursts, partial loads and drain pauses.
// ----------------------------------------------------------------------------
module matrix_add_sub_scale_multiply_tb;
    import mxops_pkg::*;

    localparam int MAX_DIM     = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_ITEMS  = 60;
    localparam int SETTLE_CYCLES = 8;

    localparam logic SEL_FIRST  = 1'b0;
    localparam logic SEL_SECOND = 1'b1;

    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_item              in_item;
    logic                  o_out_valid;
    t_out_item             o_out_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // engine model state
    t_mode                       cfg_mode;
    logic [CFG_DIM_W-1:0]        cfg_rows;
    logic [CFG_DIM_W-1:0]        cfg_inner;
    logic [CFG_DIM_W-1:0]        cfg_cols;
    logic signed [SCALE_W-1:0]   cfg_scale;
    logic signed [ELEM_W-1:0]    first_mem [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0]    second_mem [MAX_DIM*MAX_DIM];
    int                          first_count;
    int                          second_count;

    t_out_item pending_results [$];
    int        err_count;
    int        cycle_count;
    int        items_used;
    bit        idle_enabled;

    matrix_add_sub_scale_multiply #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("matrix_add_sub_scale_multiply_tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 100) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d row %0d col %0d",
                    o_out_item.value, o_out_item.out_row, o_out_item.out_col));
            end else begin
                want = pending_results.pop_front();
                if (o_out_item !== want) begin
                    report_mismatch($sformatf(
                        "got %0d r%0d c%0d l%0b, want %0d r%0d c%0d l%0b",
                        o_out_item.value, o_out_item.out_row, o_out_item.out_col,
                        o_out_item.last, want.value, want.out_row, want.out_col,
                        want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // engine model
    // ------------------------------------------------------------------
    function automatic int eff_dim(input logic [CFG_DIM_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    function automatic int first_need();
        return eff_dim(cfg_rows) * eff_dim(cfg_inner);
    endfunction

    function automatic int second_need();
        if (cfg_mode == MODE_MUL) return eff_dim(cfg_inner) * eff_dim(cfg_cols);
        if (cfg_mode == MODE_SCALE) return 0;
        return first_need();
    endfunction

    task automatic model_reset();
        cfg_mode     = RST_MODE;
        cfg_rows     = RST_DIM;
        cfg_inner    = RST_DIM;
        cfg_cols     = RST_DIM;
        cfg_scale    = RST_SCALE;
        first_count  = 0;
        second_count = 0;
    endtask

    task automatic model_reg_write(input logic [REG_IDX_W-1:0] idx,
                                   input logic [APB_DATA_W-1:0] data);
        case (idx)
            REG_MODE:         cfg_mode  = t_mode'(data[MODE_W-1:0]);
            REG_ROW_COUNT:    cfg_rows  = data[CFG_DIM_W-1:0];
            REG_INNER_COUNT:  cfg_inner = data[CFG_DIM_W-1:0];
            REG_COL_COUNT:    cfg_cols  = data[CFG_DIM_W-1:0];
            REG_SCALE_FACTOR: cfg_scale = data[SCALE_W-1:0];
            default:          return;
        endcase
        first_count  = 0;
        second_count = 0;
    endtask

    task automatic produce_result_matrix();
        int        rows;
        int        inner;
        int        cols;
        int        idx;
        longint    acc;
        t_out_item r;
        rows  = eff_dim(cfg_rows);
        inner = eff_dim(cfg_inner);
        cols  = eff_dim(cfg_cols);
        if (cfg_mode != MODE_MUL) cols = inner;
        for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
                idx = i * inner + j;
                case (cfg_mode)
                    MODE_MUL: begin
                        acc = 0;
                        for (int k = 0; k < inner; k++) begin
                            acc += longint'(first_mem[i*inner+k]) *
                                   longint'(second_mem[k*cols+j]);
                        end
                    end
                    MODE_ADD: acc = longint'(first_mem[idx]) + longint'(second_mem[idx]);
                    MODE_SUB: acc = longint'(first_mem[idx]) - longint'(second_mem[idx]);
                    default:  acc = longint'(first_mem[idx]) * longint'(cfg_scale);
                endcase
                r.value   = acc[VALUE_W-1:0];
                r.out_row = IDX_OUT_W'(i);
                r.out_col = IDX_OUT_W'(j);
                r.last    = (i == rows - 1) && (j == cols - 1);
                pending_results.push_back(r);
            end
        end
    endtask

    task automatic fold_element(input t_in_item it, output bit used);
        int na;
        int nb;
        na   = first_need();
        nb   = second_need();
        used = 1'b0;
        if (it.operand_select == SEL_FIRST) begin
            if (first_count >= na) return;
            first_mem[first_count] = it.element;
            first_count++;
        end else begin
            if (second_count >= nb) return;
            second_mem[second_count] = it.element;
            second_count++;
        end
        used = 1'b1;
        if (first_count < na || second_count < nb) return;
        produce_result_matrix();
        first_count  = 0;
        second_count = 0;
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return ELEM_MIN;
            1:       return ELEM_MAX;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic idle_burst();
        int len;
        len = $urandom_range(1, 10);
        @(negedge i_clk);
        start = 1'b0;
        repeat (len - 1) @(negedge i_clk);
    endtask

    task automatic send_item(input logic sel, input logic [ELEM_W-1:0] elem);
        t_in_item it;
        bit       used;
        if (idle_enabled && $urandom_range(0, 3) == 0) idle_burst();
        it.operand_select = sel;
        it.element        = elem;
        @(negedge i_clk);
        start   = 1'b1;
        in_item = it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        fold_element(it, used);
        if (used) items_used++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy) @(negedge i_clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        start   = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        model_reg_write(idx, data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // loads a well-formed operation, stopping after max_used accepted elements
    task automatic run_load(input int max_used);
        int na;
        int nb;
        int sa;
        int sb;
        bit pick_first;
        na = first_need();
        nb = second_need();
        sa = 0;
        sb = 0;
        while ((sa < na || sb < nb) && sa + sb < max_used) begin
            if ((sa == na || sb == nb) && $urandom_range(0, 11) == 0) begin
                send_item(sa == na ? SEL_FIRST : SEL_SECOND, rand_elem());
            end else begin
                pick_first = (sb == nb) || (sa < na && $urandom_range(0, 1) == 1);
                if (pick_first) begin
                    send_item(SEL_FIRST, rand_elem());
                    sa++;
                end else begin
                    send_item(SEL_SECOND, rand_elem());
                    sb++;
                end
            end
        end
    endtask

    function automatic logic [APB_DATA_W-1:0] random_reg_value(
        input logic [REG_IDX_W-1:0] idx);
        logic [APB_DATA_W-1:0] data;
        int                    pick;
        data = $urandom;
        pick = $urandom_range(0, 19);
        case (idx)
            REG_MODE: data[MODE_W-1:0] = MODE_W'($urandom_range(MODE_ADD, MODE_SCALE));
            REG_SCALE_FACTOR: begin
                case (pick)
                    0:       data[SCALE_W-1:0] = ELEM_MIN;
                    1:       data[SCALE_W-1:0] = ELEM_MAX;
                    2:       data[SCALE_W-1:0] = '0;
                    3:       data[SCALE_W-1:0] = '1;
                    default: data[SCALE_W-1:0] = SCALE_W'($urandom);
                endcase
            end
            default: begin
                if (pick == 0)
                    data[CFG_DIM_W-1:0] = '0;
                else if (pick == 1)
                    data[CFG_DIM_W-1:0] = CFG_DIM_W'($urandom_range(MAX_DIM + 1, 15));
                else if (pick < 4)
                    data[CFG_DIM_W-1:0] = CFG_DIM_W'(MAX_DIM);
                else
                    data[CFG_DIM_W-1:0] = CFG_DIM_W'($urandom_range(1, 4));
            end
        endcase
        return data;
    endfunction

    task automatic randomize_config();
        bit wrote;
        wait_idle();
        wrote = 1'b0;
        if ($urandom_range(0, 3) == 0) begin
            apb_write(REG_IDX_W'(REG_SCALE_FACTOR + 1 + $urandom_range(0, 2)), $urandom);
        end
        for (int k = REG_MODE; k <= REG_SCALE_FACTOR; k++) begin
            if ($urandom_range(0, 1) == 1) begin
                apb_write(REG_IDX_W'(k), random_reg_value(REG_IDX_W'(k)));
                wrote = 1'b1;
            end
        end
        if (!wrote) apb_write(REG_MODE, random_reg_value(REG_MODE));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_multiply();
        send_item(SEL_FIRST, ELEM_MIN);
        send_item(SEL_SECOND, ELEM_MIN);
    endtask

    task automatic test_add_subtract();
        wait_idle();
        apb_write(REG_MODE, APB_DATA_W'(MODE_ADD));
        apb_write(REG_INNER_COUNT, 2);
        send_item(SEL_SECOND, ELEM_MAX);
        send_item(SEL_FIRST, ELEM_MAX);
        send_item(SEL_FIRST, ELEM_MIN);
        send_item(SEL_SECOND, ELEM_MIN);
        wait_idle();
        apb_write(REG_MODE, APB_DATA_W'(MODE_SUB));
        apb_write(REG_INNER_COUNT, 1);
        send_item(SEL_FIRST, ELEM_MIN);
        // first operand already complete, ignored
        send_item(SEL_FIRST, 16'h1234);
        send_item(SEL_SECOND, ELEM_MAX);
        wait_drained();
    endtask

    task automatic test_scale();
        wait_idle();
        apb_write(REG_MODE, APB_DATA_W'(MODE_SCALE));
        apb_write(REG_SCALE_FACTOR, APB_DATA_W'(ELEM_MIN));
        // second operand is not used in scale mode
        send_item(SEL_SECOND, 16'h0001);
        send_item(SEL_FIRST, ELEM_MIN);
        wait_idle();
        apb_write(REG_SCALE_FACTOR, APB_DATA_W'(ELEM_MAX));
        send_item(SEL_FIRST, ELEM_MIN);
    endtask

    task automatic test_size_clamp();
        wait_idle();
        apb_write(REG_ROW_COUNT, 0);
        apb_write(REG_INNER_COUNT, 15);
        for (int i = 0; i < MAX_DIM; i++) begin
            send_item(SEL_FIRST, i[0] ? ELEM_MIN : ELEM_MAX);
        end
    endtask

    task automatic test_partial_load_abandon();
        wait_idle();
        apb_write(REG_MODE, APB_DATA_W'(MODE_MUL));
        apb_write(REG_ROW_COUNT, 1);
        apb_write(REG_INNER_COUNT, 1);
        apb_write(REG_COL_COUNT, 1);
        send_item(SEL_FIRST, ELEM_MAX);
        wait_idle();
        apb_write(REG_COL_COUNT, 1);
        send_item(SEL_FIRST, 16'h0001);
        send_item(SEL_SECOND, 16'hffff);
        send_item(SEL_FIRST, 16'h0005);
        wait_idle();
        // unmapped register leaves the partial load in place
        apb_write(REG_IDX_W'(REG_SCALE_FACTOR + 1), 32'hffff_ffff);
        send_item(SEL_SECOND, 16'h0007);
    endtask

    task automatic test_random_operations();
        int target;
        int total;
        int part;
        target = items_used + RANDOM_ITEMS;
        while (items_used < target) begin
            idle_enabled = (items_used < target - TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
            randomize_config();
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 5) == 0) wait_drained();
                if (items_used < target) run_load(target - items_used);
            end
            if ($urandom_range(0, 4) == 0 && items_used < target) begin
                total = first_need() + second_need();
                if (total > 1) begin
                    part = $urandom_range(1, total - 1);
                    if (part > target - items_used) part = target - items_used;
                    run_load(part);
                end
            end
        end
        idle_enabled = 1'b0;
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        in_item      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        err_count    = 0;
        cycle_count  = 0;
        items_used   = 0;
        idle_enabled = 1'b1;
        model_reset();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_multiply();
        test_add_subtract();
        test_scale();
        test_size_clamp();
        test_partial_load_abandon();
        test_random_operations();

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (err_count == 0) begin
            $display("matrix_add_sub_scale_multiply_tb OK");
        end else begin
            $display("matrix_add_sub_scale_multiply_tb NOT OK");
        end
        $finish;
    end

endmodule
